// ----- rtl/core/axui_pkg.sv -----
package axui_pkg;

    typedef enum logic [1:0] {
        PH_ADDR,
        PH_CTRL,
        PH_PID,
        PH_INFO
    } phase_t;

    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_CHAR = 3'd1;
    localparam logic [2:0] KIND_SSID = 3'd2;
    localparam logic [2:0] KIND_CTRL = 3'd3;
    localparam logic [2:0] KIND_INFO = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_CALLSIGN = 3'd2;
    localparam logic [2:0] ST_PATH     = 3'd3;
    localparam logic [2:0] ST_NOT_UI   = 3'd4;
    localparam logic [2:0] ST_INFO     = 3'd5;

    localparam logic [6:0] CHAR_SPACE = 7'h20;
    localparam logic [6:0] CHAR_MIN   = 7'h20;
    localparam logic [6:0] CHAR_MAX   = 7'h7E;
    localparam logic [7:0] CTRL_UI    = 8'h03;
    localparam logic [7:0] PID_NONE   = 8'hF0;

    localparam logic [2:0] CALL_BYTES   = 3'd6;
    localparam logic [4:0] SHORT_LEN    = 5'd16;
    localparam logic [4:0] ADDR_CNT_MAX = 5'd31;
    localparam logic [2:0] CHAR_CNT_MAX = 3'd7;
    localparam logic [8:0] PATH_ENTRY   = 9'd12;
    localparam logic [7:0] PATH_LEN_MAX = 8'd255;
    localparam logic [3:0] SSID_TWO_DIG = 4'd10;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QLVL_W  = 3;

    // classified frame byte, front to back
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       space;
        logic       bad_char;
        logic       ctrl_ok;
        logic       pid_ok;
    } item_t;

endpackage

// ----- rtl/core/axui_front.sv -----
module axui_front (
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [7:0]      s_axis_tdata,
    input  logic            s_axis_tlast,
    input  logic            q_full,
    output logic            q_push,
    output axui_pkg::item_t q_item
);

    logic [6:0] ch;

    assign ch            = s_axis_tdata[7:1];
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    always_comb
    begin
        q_item.data     = s_axis_tdata;
        q_item.last     = s_axis_tlast;
        q_item.space    = (ch == axui_pkg::CHAR_SPACE);
        q_item.bad_char = (ch < axui_pkg::CHAR_MIN) || (ch > axui_pkg::CHAR_MAX);
        q_item.ctrl_ok  = (s_axis_tdata == axui_pkg::CTRL_UI);
        q_item.pid_ok   = (s_axis_tdata == axui_pkg::PID_NONE);
    end

endmodule

// ----- rtl/core/axui_fifo.sv -----
module axui_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  axui_pkg::item_t             push_item,
    input  logic                        pop,
    output axui_pkg::item_t             pop_item,
    output logic                        not_empty,
    output logic                        full,
    output logic [axui_pkg::QLVL_W-1:0] level
);

    axui_pkg::item_t                 entry_reg [axui_pkg::QDEPTH];
    logic [axui_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [axui_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [axui_pkg::QLVL_W-1:0]     level_reg, level_next;

    assign pop_item  = entry_reg[rd_ptr_reg];
    assign not_empty = (level_reg != '0);
    assign full      = (level_reg == axui_pkg::QLVL_W'(axui_pkg::QDEPTH));
    assign level     = level_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/core/axui_back.sv -----
module axui_back #(
    parameter int MAX_INFO      = 256,
    parameter int PATH_TEXT_CAP = 80
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  axui_pkg::item_t q_item,
    output logic            q_pop,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [31:0]     m_axis_tdata,
    output logic [2:0]      m_axis_tuser,
    output logic            m_axis_tlast
);

    localparam int INFO_W = $clog2(MAX_INFO + 2);
    localparam logic [INFO_W-1:0] INFO_SAT = INFO_W'(MAX_INFO + 1);
    localparam logic [INFO_W-1:0] INFO_LIM = INFO_W'(MAX_INFO);
    localparam logic [8:0]        CAP9     = 9'(PATH_TEXT_CAP);

    axui_pkg::phase_t  phase_reg, phase_next;
    logic [4:0]        byte_cnt_reg, byte_cnt_next;
    logic [2:0]        addr_idx_reg, addr_idx_next;
    logic [4:0]        addr_cnt_reg, addr_cnt_next;
    logic [2:0]        char_cnt_reg, char_cnt_next;
    logic              pend_err_reg, pend_err_next;
    logic [2:0]        first_err_reg, first_err_next;
    logic [7:0]        path_len_reg, path_len_next;
    logic [INFO_W-1:0] info_cnt_reg, info_cnt_next;

    logic              out_valid_reg;
    logic [2:0]        kind_reg, kind_next;
    logic [4:0]        slot_reg, slot_next;
    logic [7:0]        value_reg, value_next;
    logic              alast_reg, alast_next;
    logic              done_reg;
    logic [2:0]        status_reg, status_next;
    logic [8:0]        info_len_reg, info_len_next;

    logic              take;
    logic [3:0]        ssid;
    logic              ext;
    logic              path_ovf;
    logic [3:0]        path_add;
    logic [8:0]        path_sum;
    logic [2:0]        addr_err;
    logic [4:0]        byte_cnt_inc;
    logic [INFO_W+8:0] info_wide;

    assign take  = q_valid && (!out_valid_reg || m_axis_tready);
    assign q_pop = take;
    assign ssid  = q_item.data[4:1];
    assign ext   = q_item.data[0];

    // path text: "CALL[-n][*]" joined by commas
    always_comb
    begin
        path_ovf = ({1'b0, path_len_reg} + axui_pkg::PATH_ENTRY) > CAP9;
        path_add = {1'b0, char_cnt_reg};
        if (path_len_reg != '0)
        begin
            path_add = path_add + 4'd1;
        end
        if (ssid != '0)
        begin
            path_add = path_add + ((ssid >= axui_pkg::SSID_TWO_DIG) ? 4'd3 : 4'd2);
        end
        if (ext)
        begin
            path_add = path_add + 4'd1;
        end
        path_sum = {1'b0, path_len_reg} + {5'd0, path_add};

        if ((addr_cnt_reg >= 5'd2) && path_ovf)
        begin
            addr_err = axui_pkg::ST_PATH;
        end
        else if (pend_err_reg || (char_cnt_reg == '0))
        begin
            addr_err = axui_pkg::ST_CALLSIGN;
        end
        else if ((addr_cnt_reg == '0) && ext)
        begin
            addr_err = axui_pkg::ST_SHORT;
        end
        else
        begin
            addr_err = axui_pkg::ST_OK;
        end
    end

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        addr_idx_next  = addr_idx_reg;
        addr_cnt_next  = addr_cnt_reg;
        char_cnt_next  = char_cnt_reg;
        pend_err_next  = pend_err_reg;
        first_err_next = first_err_reg;
        path_len_next  = path_len_reg;
        info_cnt_next  = info_cnt_reg;
        byte_cnt_inc   = (byte_cnt_reg == axui_pkg::SHORT_LEN) ? byte_cnt_reg
                                                               : byte_cnt_reg + 5'd1;

        unique case (phase_reg)
            axui_pkg::PH_ADDR:
            begin
                if (addr_idx_reg < axui_pkg::CALL_BYTES)
                begin
                    if (!q_item.space)
                    begin
                        if (q_item.bad_char)
                        begin
                            pend_err_next = 1'b1;
                        end
                        if (char_cnt_reg < axui_pkg::CHAR_CNT_MAX)
                        begin
                            char_cnt_next = char_cnt_reg + 3'd1;
                        end
                    end
                    addr_idx_next = addr_idx_reg + 3'd1;
                end
                else
                begin
                    if ((addr_cnt_reg >= 5'd2) && !path_ovf)
                    begin
                        path_len_next = path_sum[8] ? axui_pkg::PATH_LEN_MAX : path_sum[7:0];
                    end
                    if (first_err_reg == axui_pkg::ST_OK)
                    begin
                        first_err_next = addr_err;
                    end
                    if (ext && (addr_cnt_reg != '0))
                    begin
                        phase_next = axui_pkg::PH_CTRL;
                    end
                    if (addr_cnt_reg < axui_pkg::ADDR_CNT_MAX)
                    begin
                        addr_cnt_next = addr_cnt_reg + 5'd1;
                    end
                    addr_idx_next = '0;
                    char_cnt_next = '0;
                    pend_err_next = 1'b0;
                end
            end
            axui_pkg::PH_CTRL:
            begin
                pend_err_next = !q_item.ctrl_ok;
                phase_next    = axui_pkg::PH_PID;
            end
            axui_pkg::PH_PID:
            begin
                if ((pend_err_reg || !q_item.pid_ok) && (first_err_reg == axui_pkg::ST_OK))
                begin
                    first_err_next = axui_pkg::ST_NOT_UI;
                end
                pend_err_next = 1'b0;
                phase_next    = axui_pkg::PH_INFO;
            end
            axui_pkg::PH_INFO:
            begin
                if (info_cnt_reg < INFO_SAT)
                begin
                    info_cnt_next = info_cnt_reg + 1'b1;
                end
            end
            default:
            begin
                phase_next = axui_pkg::PH_ADDR;
            end
        endcase
        byte_cnt_next = byte_cnt_inc;
    end

    // result fields
    always_comb
    begin
        kind_next  = axui_pkg::KIND_NONE;
        slot_next  = '0;
        value_next = '0;
        alast_next = 1'b0;
        unique case (phase_reg)
            axui_pkg::PH_ADDR:
            begin
                slot_next = addr_cnt_reg;
                if (addr_idx_reg < axui_pkg::CALL_BYTES)
                begin
                    if (!q_item.space)
                    begin
                        kind_next  = axui_pkg::KIND_CHAR;
                        value_next = {1'b0, q_item.data[7:1]};
                    end
                end
                else
                begin
                    kind_next  = axui_pkg::KIND_SSID;
                    value_next = {4'd0, ssid};
                    alast_next = ext;
                end
            end
            axui_pkg::PH_CTRL, axui_pkg::PH_PID:
            begin
                kind_next  = axui_pkg::KIND_CTRL;
                value_next = q_item.data;
            end
            axui_pkg::PH_INFO:
            begin
                kind_next  = axui_pkg::KIND_INFO;
                value_next = q_item.data;
            end
            default:
            begin
                kind_next = axui_pkg::KIND_NONE;
            end
        endcase

        info_wide     = {9'd0, info_cnt_next};
        info_len_next = info_wide[8:0];

        if (!q_item.last)
        begin
            status_next = axui_pkg::ST_OK;
        end
        else if (byte_cnt_next < axui_pkg::SHORT_LEN)
        begin
            status_next = axui_pkg::ST_SHORT;
        end
        else if (first_err_next != axui_pkg::ST_OK)
        begin
            status_next = first_err_next;
        end
        else if (phase_next != axui_pkg::PH_INFO)
        begin
            status_next = axui_pkg::ST_SHORT;
        end
        else if (info_cnt_next > INFO_LIM)
        begin
            status_next = axui_pkg::ST_INFO;
        end
        else
        begin
            status_next = axui_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= axui_pkg::PH_ADDR;
            byte_cnt_reg  <= '0;
            addr_idx_reg  <= '0;
            addr_cnt_reg  <= '0;
            char_cnt_reg  <= '0;
            pend_err_reg  <= 1'b0;
            first_err_reg <= axui_pkg::ST_OK;
            path_len_reg  <= '0;
            info_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                if (q_item.last)
                begin
                    phase_reg     <= axui_pkg::PH_ADDR;
                    byte_cnt_reg  <= '0;
                    addr_idx_reg  <= '0;
                    addr_cnt_reg  <= '0;
                    char_cnt_reg  <= '0;
                    pend_err_reg  <= 1'b0;
                    first_err_reg <= axui_pkg::ST_OK;
                    path_len_reg  <= '0;
                    info_cnt_reg  <= '0;
                end
                else
                begin
                    phase_reg     <= phase_next;
                    byte_cnt_reg  <= byte_cnt_next;
                    addr_idx_reg  <= addr_idx_next;
                    addr_cnt_reg  <= addr_cnt_next;
                    char_cnt_reg  <= char_cnt_next;
                    pend_err_reg  <= pend_err_next;
                    first_err_reg <= first_err_next;
                    path_len_reg  <= path_len_next;
                    info_cnt_reg  <= info_cnt_next;
                end
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg     <= kind_next;
            slot_reg     <= slot_next;
            value_reg    <= value_next;
            alast_reg    <= alast_next;
            done_reg     <= q_item.last;
            status_reg   <= status_next;
            info_len_reg <= info_len_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = done_reg;
    assign m_axis_tdata  = {6'd0, info_len_reg, status_reg, alast_reg, value_reg, slot_reg};

endmodule

// ----- rtl/core/ax25_ui_frame_parser.sv -----
// AX.25 UI frame parser. Takes one frame byte per transfer and returns one result
// transfer per byte, in order: callsign characters, SSIDs with the extension bit,
// control/PID bytes and info bytes, with the frame status on the transfer that
// carries tlast. Throughput is one byte per clock while the output is not stalled;
// the limit is the decode state update in the back end, which retires one queued
// byte each cycle. An accepted byte is held in a four-entry queue between the input
// classifier and the decoder, and its result in the result register, which lets
// input keep flowing while a finished result waits on m_axis_tready.
module ax25_ui_frame_parser #(
    parameter int MAX_INFO      = 256,
    parameter int PATH_TEXT_CAP = 80
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_frame
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] address_slot, [12:5] value, [13] address_last, [16:14] status,
    // [25:17] info_length, [31:26] zero
    output logic [31:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // [2:0] field_kind
    output logic        m_axis_tlast    // frame_done
);

    axui_pkg::item_t                 push_item;
    axui_pkg::item_t                 pop_item;
    logic                            push;
    logic                            pop;
    logic                            q_not_empty;
    logic                            q_full;
    logic [axui_pkg::QLVL_W-1:0]     q_level;

    axui_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (push),
        .q_item        (push_item)
    );

    axui_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (q_not_empty),
        .full      (q_full),
        .level     (q_level)
    );

    axui_back #(
        .MAX_INFO      (MAX_INFO),
        .PATH_TEXT_CAP (PATH_TEXT_CAP)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_not_empty),
        .q_item        (pop_item),
        .q_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= axui_pkg::QLVL_W'(axui_pkg::QDEPTH))
        else $error("queue level above depth");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (q_level == axui_pkg::QLVL_W'(axui_pkg::QDEPTH)))
        else $error("input stalled with queue space left");

    a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[16:14] == axui_pkg::ST_OK))
        else $error("status on a non-final result");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= axui_pkg::KIND_INFO))
        else $error("field kind out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (q_level == '0) |=> ($past(push) || (q_level == '0)))
        else $error("queue level rose without a push");

endmodule
